>>> sv/hbd_pkg.sv
// shared constants and types for the heartbeat detector
package hbd_pkg;

  // default parameter values
  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int SAMPLE_BITS_DEF   = 12;

  // fixed field widths
  localparam int TICK_W     = 4;
  localparam int GAP_W      = 10;
  localparam int LOST_W     = 12;
  localparam int LEVEL_W    = 12;
  localparam int IVL_W      = 12;
  localparam int RATE_W     = 9;
  localparam int ELAP_W     = 13;
  localparam int BPM_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // register reset values
  localparam logic [TICK_W-1:0]  TICK_STEP_RST  = 4'd2;
  localparam logic [GAP_W-1:0]   MIN_GAP_RST    = 10'd250;
  localparam logic [LOST_W-1:0]  LOST_RST       = 12'd2500;
  localparam logic [LEVEL_W-1:0] REST_LEVEL_RST = 12'd2048;

  // detection state reset values
  localparam logic [LEVEL_W-1:0] AMP_RST = 12'd410;
  localparam logic [IVL_W-1:0]   IVL_RST = 12'd600;

  // limits and arithmetic constants
  localparam logic [ELAP_W-1:0] ELAPSED_MAX = 13'd8191;
  localparam logic [IVL_W-1:0]  IVL_MAX     = 12'd4095;
  localparam logic [RATE_W-1:0] RATE_MAX    = 9'd511;
  localparam logic [BPM_W-1:0]  BPM_NUM     = 16'd60000;

  // reciprocal of five, exact for 12-bit values after the shift
  localparam logic [IVL_W-1:0] RECIP5    = 12'd3277;
  localparam int               RECIP5_SH = 14;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_STEP,
    REG_MIN_GAP,
    REG_LOST,
    REG_REST_LEVEL
  } cfg_reg_t;

endpackage

>>> sv/hbd_ram.sv
// interval history memory, one write and one registered read port
module hbd_ram #(
  parameter int DEPTH = hbd_pkg::HISTORY_DEPTH_DEF,
  parameter int WIDTH = hbd_pkg::IVL_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/hbd_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module hbd_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // trial subtraction of the next dividend bit
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> sv/heartbeat_detector.sv
// heartbeat detector top level: beat tracking, interval history and rate
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_sample
//   out      output     out_valid / out_stall pulse_high, beat_found, beats_per_minute,
//                                             interval_ms, amplitude, signal_lost
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// a sample without a rate update goes through accept, evaluate and hand to the output register
// a beat that updates the rate goes on through history read, history update, average, divider
// start and divider wait; the average is a reciprocal multiply, the rate a 16-bit serial division
// the second beat after reset or a loss first fills every entry of the history memory
// reset is synchronous and active low; the history memory is not cleared
// a finished item waits in the output register while the next sample is accepted
module heartbeat_detector #(
  parameter int HISTORY_DEPTH = hbd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = hbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pulse_high,
  output logic                             out_beat_found,
  output logic [hbd_pkg::RATE_W-1:0]       out_beats_per_minute,
  output logic [hbd_pkg::IVL_W-1:0]        out_interval_ms,
  output logic [SAMPLE_BITS-1:0]           out_amplitude,
  output logic                             out_signal_lost,
  input  logic                             cfg_we,
  input  logic [hbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import hbd_pkg::*;

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = IVL_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W = BPM_W;
  localparam int SB    = SAMPLE_BITS;

  // reciprocal of the history depth, exact for every sum below 2^SUM_W
  localparam int AVG_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int RCP_W  = SUM_W + 1;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH));

  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
  localparam logic [SB-1:0] THR_RST  = SB'(REST_LEVEL_RST);
  localparam logic [SB-1:0] AMP_INIT = SB'(AMP_RST);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SEED,
    S_RD,
    S_UPD,
    S_AVG,
    S_RATE,
    S_RATEW,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [TICK_W-1:0]  tick_r;
  logic [GAP_W-1:0]   min_gap_r;
  logic [LOST_W-1:0]  lost_ms_r;
  logic [LEVEL_W-1:0] rest_r;

  // detection state
  logic [ELAP_W-1:0] elapsed_r;
  logic [SB-1:0]     thr_r;
  logic [SB-1:0]     peak_r;
  logic [SB-1:0]     trough_r;
  logic [SB-1:0]     amp_r;
  logic [IVL_W-1:0]  li_r;
  logic [RATE_W-1:0] rate_r;
  logic              pulse_r;
  logic              first_r;
  logic              second_r;

  // per-item working registers
  logic [SB-1:0]     s_r;
  logic [IVL_W-1:0]  guard_r;
  logic              found_r;
  logic              lost_r;
  logic              go_bpm_r;
  logic [AW-1:0]     seed_r;
  logic [AW-1:0]     head_r;
  logic [SUM_W-1:0]  sum_r;
  logic [IVL_W-1:0]  avg_r;

  // output register
  logic              out_valid_r;
  logic              out_pulse_r;
  logic              out_found_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [IVL_W-1:0]  out_ivl_r;
  logic [SB-1:0]     out_amp_r;
  logic              out_lost_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= TICK_STEP_RST;
      min_gap_r <= MIN_GAP_RST;
      lost_ms_r <= LOST_RST;
      rest_r    <= REST_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TICK_STEP:  tick_r    <= TICK_W'(cfg_data);
        REG_MIN_GAP:    min_gap_r <= GAP_W'(cfg_data);
        REG_LOST:       lost_ms_r <= LOST_W'(cfg_data);
        REG_REST_LEVEL: rest_r    <= LEVEL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // elapsed time advance, saturating
  logic [ELAP_W:0]   e_sum;
  logic [ELAP_W-1:0] elapsed_adv;
  assign e_sum       = (ELAP_W + 1)'(elapsed_r) + (ELAP_W + 1)'(tick_r);
  assign elapsed_adv = (e_sum > (ELAP_W + 1)'(ELAPSED_MAX)) ? ELAPSED_MAX : e_sum[ELAP_W-1:0];

  // refractory guard, three fifths of the last interval
  logic [2*IVL_W-1:0] g_prod;
  logic [IVL_W-1:0]   g_fifth;
  logic [IVL_W-1:0]   guard_nxt;
  assign g_prod    = (2 * IVL_W)'(li_r) * (2 * IVL_W)'(RECIP5);
  assign g_fifth   = IVL_W'(g_prod >> RECIP5_SH);
  assign guard_nxt = IVL_W'({g_fifth, 1'b0} + (IVL_W + 1)'(g_fifth));

  // step evaluation
  logic              s_lo, s_hi, past_guard, beat, early, fall, lost_now;
  logic              seed_now, bpm_now;
  logic [SB-1:0]     trough_a, peak_a, amp_raw, thr_fall, rest_thr;
  logic [IVL_W-1:0]  ivl_new;
  logic [SB-1:0]     thr_nxt, peak_nxt, trough_nxt, amp_nxt;
  logic [IVL_W-1:0]  li_nxt;
  logic [ELAP_W-1:0] elapsed_nxt;
  logic              pulse_nxt, first_nxt, second_nxt;

  always_comb begin
    s_lo       = (s_r < thr_r);
    s_hi       = (s_r > thr_r);
    past_guard = (elapsed_r > ELAP_W'(guard_r));
    trough_a   = (s_lo && past_guard && (s_r < trough_r)) ? s_r : trough_r;
    peak_a     = (s_hi && (s_r > peak_r)) ? s_r : peak_r;
    beat       = (elapsed_r > ELAP_W'(min_gap_r)) && s_hi && !pulse_r && past_guard;
    early      = beat && first_r;
    seed_now   = beat && second_r;
    bpm_now    = beat && !first_r;
    ivl_new    = (elapsed_r > ELAP_W'(IVL_MAX)) ? IVL_MAX : elapsed_r[IVL_W-1:0];
    fall       = s_lo && pulse_r;
    amp_raw    = (peak_a >= trough_a) ? SB'(peak_a - trough_a) : '0;
    thr_fall   = SB'((SB + 1)'(amp_raw >> 1) + (SB + 1)'(trough_a));
    lost_now   = !early && (elapsed_r > ELAP_W'(lost_ms_r));
    rest_thr   = SB'(rest_r);

    // threshold and envelope: silence reset wins over end of pulse
    if (lost_now) begin
      thr_nxt    = rest_thr;
      peak_nxt   = rest_thr;
      trough_nxt = rest_thr;
    end else if (fall) begin
      thr_nxt    = thr_fall;
      peak_nxt   = thr_fall;
      trough_nxt = thr_fall;
    end else begin
      thr_nxt    = thr_r;
      peak_nxt   = peak_a;
      trough_nxt = trough_a;
    end

    amp_nxt     = fall ? amp_raw : amp_r;
    pulse_nxt   = beat ? 1'b1 : (fall ? 1'b0 : pulse_r);
    li_nxt      = beat ? ivl_new : li_r;
    elapsed_nxt = (beat || lost_now) ? '0 : elapsed_r;
    first_nxt   = lost_now ? 1'b1 : (beat ? 1'b0 : first_r);
    second_nxt  = lost_now ? 1'b0 : (beat ? first_r : second_r);
  end

  // history average by reciprocal multiplication
  logic [SUM_W+RCP_W-1:0] avg_prod;
  logic [IVL_W-1:0]       avg_nxt;
  assign avg_prod = (SUM_W + RCP_W)'(sum_r) * (SUM_W + RCP_W)'(AVG_RCP);
  assign avg_nxt  = IVL_W'(avg_prod >> AVG_SH);

  // serial divider for the rate
  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_num, div_quot;
  logic [IVL_W-1:0] div_den;

  assign div_start = (state_r == S_RATE);
  assign div_num   = DIV_W'(BPM_NUM);
  assign div_den   = avg_r;

  hbd_div #(
    .NUM_W (DIV_W),
    .DEN_W (IVL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // interval history memory, used as a ring with head at the oldest entry
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [IVL_W-1:0] ram_rdata;

  assign ram_we    = (state_r == S_SEED) || (state_r == S_UPD);
  assign ram_waddr = (state_r == S_SEED) ? seed_r : head_r;
  assign ram_re    = (state_r == S_RD);

  hbd_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (IVL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (li_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // sequencer with state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elapsed_r   <= '0;
      thr_r       <= THR_RST;
      peak_r      <= THR_RST;
      trough_r    <= THR_RST;
      amp_r       <= AMP_INIT;
      li_r        <= IVL_RST;
      rate_r      <= '0;
      pulse_r     <= 1'b0;
      first_r     <= 1'b1;
      second_r    <= 1'b0;
      found_r     <= 1'b0;
      lost_r      <= 1'b0;
      go_bpm_r    <= 1'b0;
      seed_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output item taken, unless a new one is loaded in the same cycle
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            s_r       <= in_sample;
            elapsed_r <= elapsed_adv;
            guard_r   <= guard_nxt;
            state_r   <= S_EVAL;
          end
        end

        S_EVAL: begin
          thr_r     <= thr_nxt;
          peak_r    <= peak_nxt;
          trough_r  <= trough_nxt;
          amp_r     <= amp_nxt;
          li_r      <= li_nxt;
          elapsed_r <= elapsed_nxt;
          pulse_r   <= pulse_nxt;
          first_r   <= first_nxt;
          second_r  <= second_nxt;
          found_r   <= 1'b0;
          lost_r    <= lost_now;
          go_bpm_r  <= bpm_now;
          seed_r    <= '0;
          if (seed_now) begin
            state_r <= S_SEED;
          end else if (bpm_now) begin
            state_r <= S_RD;
          end else begin
            state_r <= S_DONE;
          end
        end

        // fill every history entry with the first interval
        S_SEED: begin
          sum_r  <= SUM_W'(li_r) * SUM_W'(HISTORY_DEPTH);
          seed_r <= seed_r + 1'b1;
          if (seed_r == LAST_IDX) begin
            state_r <= go_bpm_r ? S_RD : S_DONE;
          end
        end

        S_RD: begin
          state_r <= S_UPD;
        end

        // replace the oldest interval and keep the running sum
        S_UPD: begin
          sum_r   <= sum_r - SUM_W'(ram_rdata) + SUM_W'(li_r);
          head_r  <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          state_r <= S_AVG;
        end

        // average of the history; a zero average gives the top rate
        S_AVG: begin
          avg_r <= avg_nxt;
          if (avg_nxt == '0) begin
            rate_r  <= RATE_MAX;
            found_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RATE;
          end
        end

        S_RATE: begin
          state_r <= S_RATEW;
        end

        S_RATEW: begin
          if (div_done) begin
            rate_r  <= (div_quot > DIV_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(div_quot);
            found_r <= 1'b1;
            state_r <= S_DONE;
          end
        end

        // hand the item to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pulse_r <= pulse_r;
            out_found_r <= found_r;
            out_rate_r  <= rate_r;
            out_ivl_r   <= li_r;
            out_amp_r   <= amp_r;
            out_lost_r  <= lost_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_pulse_high       = out_pulse_r;
  assign out_beat_found       = out_found_r;
  assign out_beats_per_minute = out_rate_r;
  assign out_interval_ms      = out_ivl_r;
  assign out_amplitude        = out_amp_r;
  assign out_signal_lost      = out_lost_r;

`ifndef SYNTHESIS
  // divider is never restarted mid-division
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("divider started while busy");

  // history update only follows the read of the oldest entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ($past(state_r) == S_RD))
    else $error("history update without preceding read");

  // rate division never by zero
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_RATE) |-> (avg_r != '0))
    else $error("rate division by zero average");

  // a new rate always comes with the pulse high
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat_found) |-> out_pulse_high)
    else $error("beat reported without pulse high");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the heartbeat detector: pulse trains, silences and noise
module testbench;
  import hbd_pkg::*;

  localparam int HIST_LEN       = HISTORY_DEPTH_DEF;
  localparam int SMP_W          = SAMPLE_BITS_DEF;
  localparam int SMP_MAX        = (1 << SMP_W) - 1;
  localparam int STALL_PCT      = 29;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct packed {
    logic              pulse_high;
    logic              beat_found;
    logic [RATE_W-1:0] bpm;
    logic [IVL_W-1:0]  interval;
    logic [SMP_W-1:0]  amplitude;
    logic              signal_lost;
  } beat_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SMP_W-1:0]      in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_pulse_high;
  logic                  out_beat_found;
  logic [RATE_W-1:0]     out_beats_per_minute;
  logic [IVL_W-1:0]      out_interval_ms;
  logic [SMP_W-1:0]      out_amplitude;
  logic                  out_signal_lost;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pending samples and expected results
  logic [SMP_W-1:0] sample_q[$];
  beat_result_t     beat_expect_q[$];

  int samples_sent = 0;
  int results_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;

  // register copies
  int step_ms = TICK_STEP_RST;
  int gap_ms = MIN_GAP_RST;
  int silence_ms = LOST_RST;
  int rest_lvl = REST_LEVEL_RST;

  // detector state as it should be after reset
  int ms_since_beat = 0;
  int thresh_lvl = REST_LEVEL_RST;
  int peak_lvl = REST_LEVEL_RST;
  int trough_lvl = REST_LEVEL_RST;
  int amp_lvl = AMP_RST;
  int last_ivl_ms = IVL_RST;
  int rate_bpm = 0;
  bit in_pulse = 1'b0;
  bit await_first = 1'b1;
  bit await_second = 1'b0;
  int ivl_hist[HIST_LEN];

  heartbeat_detector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pulse_high       (out_pulse_high),
    .out_beat_found       (out_beat_found),
    .out_beats_per_minute (out_beats_per_minute),
    .out_interval_ms      (out_interval_ms),
    .out_amplitude        (out_amplitude),
    .out_signal_lost      (out_signal_lost),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #4 clk = ~clk;

  // beat tracking for one sample, updates the state copy
  function automatic beat_result_t track_sample(logic [SMP_W-1:0] smp);
    int s;
    int n;
    int guard;
    int sum;
    int avg;
    int bpm;
    beat_result_t r;
    s = smp;
    r = '0;
    n = ms_since_beat + step_ms;
    if (n > ELAPSED_MAX) n = ELAPSED_MAX;
    ms_since_beat = n;
    guard = (last_ivl_ms / 5) * 3;

    // trough and peak follow the wave
    if (s < thresh_lvl && n > guard && s < trough_lvl) trough_lvl = s;
    if (s > thresh_lvl && s > peak_lvl) peak_lvl = s;

    // rising crossing after the gap counts as a beat
    if (n > gap_ms && s > thresh_lvl && !in_pulse && n > guard) begin
      in_pulse = 1'b1;
      last_ivl_ms = (n > IVL_MAX) ? IVL_MAX : n;
      ms_since_beat = 0;
      if (await_second) begin
        await_second = 1'b0;
        foreach (ivl_hist[i]) ivl_hist[i] = last_ivl_ms;
      end
      // first beat only arms the detector
      if (await_first) begin
        await_first = 1'b0;
        await_second = 1'b1;
        r.pulse_high = 1'b1;
        r.bpm = RATE_W'(rate_bpm);
        r.interval = IVL_W'(last_ivl_ms);
        r.amplitude = SMP_W'(amp_lvl);
        return r;
      end
      sum = 0;
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        ivl_hist[i] = ivl_hist[i + 1];
        sum += ivl_hist[i];
      end
      ivl_hist[HIST_LEN - 1] = last_ivl_ms;
      sum += last_ivl_ms;
      avg = sum / HIST_LEN;
      bpm = (avg == 0) ? RATE_MAX : BPM_NUM / avg;
      rate_bpm = (bpm > RATE_MAX) ? RATE_MAX : bpm;
      r.beat_found = 1'b1;
    end

    // end of pulse re-centres the threshold
    if (s < thresh_lvl && in_pulse) begin
      in_pulse = 1'b0;
      amp_lvl = (peak_lvl >= trough_lvl) ? peak_lvl - trough_lvl : 0;
      thresh_lvl = (amp_lvl / 2 + trough_lvl) & SMP_MAX;
      peak_lvl = thresh_lvl;
      trough_lvl = thresh_lvl;
    end

    // long silence goes back to rest
    if (n > silence_ms) begin
      thresh_lvl = rest_lvl & SMP_MAX;
      peak_lvl = thresh_lvl;
      trough_lvl = thresh_lvl;
      ms_since_beat = 0;
      await_first = 1'b1;
      await_second = 1'b0;
      r.signal_lost = 1'b1;
    end

    r.pulse_high = in_pulse;
    r.bpm = RATE_W'(rate_bpm);
    r.interval = IVL_W'(last_ivl_ms);
    r.amplitude = SMP_W'(amp_lvl);
    return r;
  endfunction

  function automatic bit calm_stretch();
    return samples_sent >= 600 && samples_sent < 800;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    beat_result_t want;
    if (beat_expect_q.size() == 0) begin
      $error("result item with no expectation pending");
      fail_count++;
      return;
    end
    want = beat_expect_q.pop_front();
    check_field("pulse_high", want.pulse_high, out_pulse_high);
    check_field("beat_found", want.beat_found, out_beat_found);
    check_field("beats_per_minute", want.bpm, out_beats_per_minute);
    check_field("interval_ms", want.interval, out_interval_ms);
    check_field("amplitude", want.amplitude, out_amplitude);
    check_field("signal_lost", want.signal_lost, out_signal_lost);
  endtask

  // input driver: offers queued samples, idles at random outside the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        beat_expect_q.push_back(track_sample(in_sample));
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 &&
            !(!calm_stretch() && $urandom_range(0, 99) < STALL_PCT)) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
        if (results_seen == 300 || results_seen == 950) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm_stretch() && $urandom_range(0, 99) < STALL_PCT;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || beat_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_TICK_STEP:  step_ms = value & ((1 << TICK_W) - 1);
      REG_MIN_GAP:    gap_ms = value & ((1 << GAP_W) - 1);
      REG_LOST:       silence_ms = value & ((1 << LOST_W) - 1);
      REG_REST_LEVEL: rest_lvl = value & ((1 << LEVEL_W) - 1);
      default: ;
    endcase
  endtask

  // registers change only once the block has drained
  task automatic set_registers(int tick, int gap, int lost, int rest);
    wait_drained();
    write_reg(REG_TICK_STEP, tick);
    write_reg(REG_MIN_GAP, gap);
    write_reg(REG_LOST, lost);
    write_reg(REG_REST_LEVEL, rest);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one setting followed by a mix of pulse trains, silences and noise
  task automatic run_phase(int tick, int gap, int lost, int rest, int count,
                           int per_lo, int per_hi);
    int added;
    int period;
    int high_len;
    int base;
    int swing;
    int mode;
    int sil_len;
    int lvl;
    set_registers(tick, gap, lost, rest);
    sil_len = (tick == 0) ? 20 : lost / tick - 1;
    if (sil_len > 300) sil_len = 300;
    if (sil_len < 1) sil_len = 1;
    base = $urandom_range(200, 1700);
    swing = $urandom_range(2100 - base, 4000 - base);
    added = 0;
    while (added < count) begin
      mode = $urandom_range(0, 99);
      // baseline and swing drift now and then
      if (mode < 6) begin
        base = $urandom_range(200, 1700);
        swing = $urandom_range(2100 - base, 4000 - base);
      end
      if (mode < 78) begin
        period = $urandom_range(per_lo, per_hi);
        high_len = $urandom_range(1, period / 3 + 1);
      end else if (mode < 86) begin
        // flat stretch around the silence limit
        period = sil_len + $urandom_range(0, 4);
        high_len = 0;
      end else if (mode < 93) begin
        // broken pulses: very short, or stuck high
        if ($urandom_range(0, 1)) begin
          period = $urandom_range(1, 3);
          high_len = 1;
        end else begin
          period = 2 * per_hi;
          high_len = period;
        end
      end else begin
        period = $urandom_range(1, 10);
        high_len = -1;
      end
      for (int j = 0; j < period && added < count; j++) begin
        if (high_len < 0) begin
          if ($urandom_range(0, 3) == 0) lvl = $urandom_range(0, 1) ? SMP_MAX : 0;
          else lvl = $urandom_range(0, SMP_MAX);
        end else begin
          lvl = ((j < high_len) ? base + swing : base) + $urandom_range(0, 60);
          if (lvl > SMP_MAX) lvl = SMP_MAX;
        end
        sample_q.push_back(lvl[SMP_W-1:0]);
        added++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // opening items: sample extremes, a sample equal to the threshold,
    // a long low stretch and then the first beat, which is discarded
    set_registers(15, 200, 4000, 2048);
    sample_q.push_back('0);
    sample_q.push_back(SMP_MAX[SMP_W-1:0]);
    sample_q.push_back(12'd2048);
    repeat (21) sample_q.push_back(12'd1000);
    sample_q.push_back(SMP_MAX[SMP_W-1:0]);

    // settings sweep, extremes included
    run_phase(15, 200, 1000, 2048, 250, 30, 60);
    run_phase(8, 300, 2500, 1500, 200, 60, 110);
    run_phase(15, 0, 4095, 0, 200, 3, 10);
    run_phase(1, 1023, 4000, 3000, 100, 20, 40);
    run_phase(0, 500, 0, 4095, 40, 2, 8);
    run_phase(15, 1023, 0, 100, 40, 5, 20);
    run_phase(6, 250, 2500, 2048, 250, 70, 150);
    run_phase($urandom_range(10, 15), $urandom_range(200, 400), $urandom_range(1000, 3000),
              $urandom_range(1500, 2500), 100, 25, 60);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && beat_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
